>>> hdl/fmtb_pkg.sv
// Package for the FIFO with move-to-back: entry layout, action and status codes,
// and the command/status bundles between the controller and the datapath.
// No dependencies.
package fmtb_pkg;

    // Default queue depth (entries)
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int LOW_W  = 64;
    localparam int MID_W  = 64;
    localparam int HIGH_W = 32;

    // Action codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One queue entry: key plus the 20-character name in three parts
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LOW_W-1:0]  name_low;
        logic [MID_W-1:0]  name_middle;
        logic [HIGH_W-1:0] name_high;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted item, reset walk state
        logic push;      // append the captured entry
        logic pop;       // read and remove the head entry
        logic walk;      // one step of the move-to-back walk
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_done; // walk finished, append handled this cycle
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

>>> hdl/fmtb_ctrl.sv
// Controller for the FIFO with move-to-back: one-hot state machine that
// sequences push, pop and the move-to-back walk. Depends on fmtb_pkg.
module fmtb_ctrl
    import fmtb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    output logic       o_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PUSH   = 5'b00010,
        S_POP    = 5'b00100,
        S_WALK   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // Input side only open while idle and out of reset
    assign o_stall = !i_rst_n || (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_PUSH: n_state = S_PUSH;
                        ACT_POP:  n_state = S_POP;
                        ACT_MOVE: n_state = S_WALK;
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FINISH;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait here while the previous result is still held
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/fmtb_dpath.sv
// Datapath for the FIFO with move-to-back: entry memory, head/count pointers,
// compaction walk and the output register. Depends on fmtb_pkg.
module fmtb_dpath
    import fmtb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [1:0]        i_action,
    input  logic [KEY_W-1:0]  i_entry_key,
    input  logic [LOW_W-1:0]  i_name_low,
    input  logic [MID_W-1:0]  i_name_middle,
    input  logic [HIGH_W-1:0] i_name_high,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_result_status,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [LOW_W-1:0]  o_out_name_low,
    output logic [MID_W-1:0]  o_out_name_middle,
    output logic [HIGH_W-1:0] o_out_name_high,
    output logic [CW-1:0]     o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

    // Slot of an offset from the head; the sum stays below twice the depth
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    t_entry        r_in, n_in;
    logic [1:0]    r_act, n_act;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_kept, n_kept;
    logic          r_pend, n_pend;
    logic          r_found, n_found;
    t_entry        r_match, n_match;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_entry        r_out, n_out;
    logic [1:0]    r_out_status, n_out_status;
    logic [CW-1:0] r_out_occ, n_out_occ;

    logic          we, rd_en, rd_issue, walk_done;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata;

    assign rd_issue         = i_cmd.walk && (r_rd_idx != r_count);
    assign walk_done        = (r_rd_idx == r_count) && !r_pend;
    assign o_stat.walk_done = walk_done;
    assign o_stat.out_free  = !r_out_valid || !i_stall;

    // Command decode and next values
    always_comb begin
        n_in         = r_in;
        n_act        = r_act;
        n_head       = r_head;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_kept       = r_kept;
        n_pend       = r_pend;
        n_found      = r_found;
        n_match      = r_match;
        n_status     = r_status;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        n_out_valid  = r_out_valid;
        we           = 1'b0;
        waddr        = r_head;
        wdata        = r_in;
        rd_en        = 1'b0;
        raddr        = r_head;

        // capture the accepted item
        if (i_cmd.load) begin
            n_in.key         = i_entry_key;
            n_in.name_low    = i_name_low;
            n_in.name_middle = i_name_middle;
            n_in.name_high   = i_name_high;
            n_act            = i_action;
            n_rd_idx         = '0;
            n_kept           = '0;
            n_pend           = 1'b0;
            n_found          = 1'b0;
            n_status         = ST_OK;
        end

        // push at the tail
        if (i_cmd.push) begin
            if (r_count == DEPTH_C) begin
                n_status = ST_FULL;
            end else begin
                we      = 1'b1;
                waddr   = f_slot(r_head, r_count);
                wdata   = r_in;
                n_count = r_count + CW'(1);
            end
        end

        // pop the head; entry lands in r_rdata
        if (i_cmd.pop) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                rd_en   = 1'b1;
                raddr   = r_head;
                n_head  = f_slot(r_head, CW'(1));
                n_count = r_count - CW'(1);
            end
        end

        // walk: read one entry a cycle, compact the non-matching ones
        if (i_cmd.walk) begin
            rd_en    = rd_issue;
            raddr    = f_slot(r_head, r_rd_idx);
            n_rd_idx = r_rd_idx + CW'(rd_issue);
            n_pend   = rd_issue;
            if (r_pend) begin
                if (r_rdata.key == r_in.key) begin
                    n_found = 1'b1;
                    n_match = r_rdata;
                end else begin
                    we     = 1'b1;
                    waddr  = f_slot(r_head, r_kept);
                    wdata  = r_rdata;
                    n_kept = r_kept + CW'(1);
                end
            end
            // append the last match behind the kept entries
            if (walk_done) begin
                if (r_found) begin
                    we       = 1'b1;
                    waddr    = f_slot(r_head, r_kept);
                    wdata    = r_match;
                    n_count  = r_kept + CW'(1);
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end

        // output register
        if (i_cmd.load_out) begin
            n_out_valid  = 1'b1;
            n_out_status = r_status;
            n_out_occ    = r_count;
            if ((r_act == ACT_POP) && (r_status == ST_OK)) begin
                n_out = r_rdata;
            end else begin
                n_out = '0;
            end
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_kept      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_kept      <= n_kept;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_act        <= n_act;
        r_match      <= n_match;
        r_status     <= n_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    assign o_valid           = r_out_valid;
    assign o_result_status   = r_out_status;
    assign o_out_key         = r_out.key;
    assign o_out_name_low    = r_out.name_low;
    assign o_out_name_middle = r_out.name_middle;
    assign o_out_name_high   = r_out.name_high;
    assign o_occupancy       = r_out_occ;

endmodule

>>> hdl/fifo_with_move_to_back.sv
// FIFO with move-to-back, top level. An accepted item is captured, then push or pop runs in its
// own state and the result moves to the output register. Move-to-back instead walks the queue:
// the single memory read port reads one entry a cycle, compacting behind it, then appends.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset (i_rst_n, synchronous, active low) empties the queue; entry memory is not cleared.
module fifo_with_move_to_back
    import fmtb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [KEY_W-1:0]  i_entry_key,
    input  logic [LOW_W-1:0]  i_name_low,
    input  logic [MID_W-1:0]  i_name_middle,
    input  logic [HIGH_W-1:0] i_name_high,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_result_status,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [LOW_W-1:0]  o_out_name_low,
    output logic [MID_W-1:0]  o_out_name_middle,
    output logic [HIGH_W-1:0] o_out_name_high,
    output logic [CW-1:0]     o_occupancy
);

    t_cmd  cmd;
    t_stat stat;

    fmtb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    fmtb_dpath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_action),
        .i_entry_key       (i_entry_key),
        .i_name_low        (i_name_low),
        .i_name_middle     (i_name_middle),
        .i_name_high       (i_name_high),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_result_status   (o_result_status),
        .o_out_key         (o_out_key),
        .o_out_name_low    (o_out_name_low),
        .o_out_name_middle (o_out_name_middle),
        .o_out_name_high   (o_out_name_high),
        .o_occupancy       (o_occupancy)
    );

endmodule
